// File: hdl/assert_macros.svh
// Assertion helpers, sampled on clk, muted while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge out of reset.
`define CDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a rising edge out of reset.
`define CDQ_NEVER(label, cond, msg) \
    `CDQ_ASSERT(label, !(cond), msg)

`endif

// File: hdl/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CAP_W     = 5;
    localparam int DATA_W    = 32;
    localparam int CMD_W     = 3;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } cdq_wr_t;

    typedef struct packed {
        logic              re;
        logic [IDX_W-1:0]  addr_front;
        logic [IDX_W-1:0]  addr_rear;
    } cdq_rd_t;

    // capacity 0 acts as 1, anything above the built depth saturates
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0)
            r = CNT_W'(1);
        else if (int'(c) > DEPTH)
            r = CNT_W'(DEPTH);
        else
            r = CNT_W'(c);
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] i,
                                                   input logic [CNT_W-1:0] cap);
        logic [IDX_W-1:0] r;
        if (int'(i) + 1 >= int'(cap))
            r = '0;
        else
            r = IDX_W'(int'(i) + 1);
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] i,
                                                    input logic [CNT_W-1:0] cap);
        logic [IDX_W-1:0] r;
        if (i == '0 || int'(i) >= int'(cap))
            r = IDX_W'(int'(cap) - 1);
        else
            r = IDX_W'(int'(i) - 1);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/cdq_cmd_if.sv
`default_nettype none

interface cdq_cmd_if
    import cdq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

`default_nettype wire

// File: hdl/cdq_rsp_if.sv
`default_nettype none

interface cdq_rsp_if
    import cdq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// File: hdl/cdq_ram.sv
`default_nettype none

module cdq_ram
    import cdq_pkg::*;
(
    input  wire logic              clk,
    input  wire cdq_wr_t           wr,
    input  wire cdq_rd_t           rd,
    output logic [DATA_W-1:0]      rdata_front,
    output logic [DATA_W-1:0]      rdata_rear
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // two registered read ports, held while re is low
    always_ff @(posedge clk)
    begin
        if (rd.re)
        begin
            rdata_front <= mem[rd.addr_front];
            rdata_rear  <= mem[rd.addr_rear];
        end
    end

endmodule

`default_nettype wire

// File: hdl/circular_deque.sv
// circular_deque: double-ended queue of 32-bit words in a 16-entry circular store.
// cmd_ch (valid/ready) carries an item: cmd and value. Commands push at the front
// or rear, pop at the front or rear, or only query; unknown codes act as a query.
// rsp_ch (valid/ready) returns one item per command: ok, front_value, rear_value
// (-1 when empty), is_empty and is_full, all as they stand after the command.
// cfg_we/cfg_wdata write the capacity register (reset 16; 0 acts as 1, values
// above 16 act as 16). Write it only while no command is outstanding.
// Timing: accepting a command updates the pointers and writes the store; the
// next cycle reads the front and rear slots through the store's two registered
// read ports, and the response valid flag is registered along with that read data.
// One command is in flight at a time: no new command is taken while one is
// being read from the store.
// The next command is taken in the same cycle its predecessor's response is
// taken; while the receiver stalls, the response holds and cmd_ch.ready is low.
// Reset (rst_n, asynchronous, active low) empties the deque and zeroes both
// pointers; the store contents are not cleared and no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module circular_deque
    import cdq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    cdq_cmd_if.sink                cmd_ch,
    cdq_rsp_if.source              rsp_ch,
    input  wire logic              cfg_we,
    input  wire logic [CAP_W-1:0]  cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic              ok_reg, ok_next;
    logic              full_reg, full_next;
    logic              out_valid_reg, out_valid_next;

    logic              accept;
    logic [CNT_W-1:0]  cap;
    cdq_wr_t           wr;
    cdq_rd_t           rd;
    logic [DATA_W-1:0] rdata_front;
    logic [DATA_W-1:0] rdata_rear;

    cdq_ram u_ram (
        .clk         (clk),
        .wr          (wr),
        .rd          (rd),
        .rdata_front (rdata_front),
        .rdata_rear  (rdata_rear)
    );

    assign cmd_ch.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp_ch.ready);
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign cap          = eff_cap(capacity_reg);

    assign rd.re         = (state_reg == S_READ);
    assign rd.addr_front = head_reg;
    assign rd.addr_rear  = tail_reg;

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        ok_next        = ok_reg;
        full_next      = full_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        wr.we          = 1'b0;
        wr.addr        = '0;
        wr.data        = cmd_ch.value;

        if (out_valid_reg && rsp_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ok_next    = 1'b1;
                    state_next = S_READ;
                    case (cmd_ch.cmd) inside
                        CMD_PUSH_FRONT, CMD_PUSH_REAR:
                        begin
                            if (occ_reg >= cap)
                            begin
                                ok_next = 1'b0;
                            end
                            else if (occ_reg == '0)
                            begin
                                head_next = '0;
                                tail_next = '0;
                                occ_next  = CNT_W'(1);
                                wr.we     = 1'b1;
                                wr.addr   = '0;
                            end
                            else if (cmd_ch.cmd == CMD_PUSH_FRONT)
                            begin
                                head_next = step_back(head_reg, cap);
                                occ_next  = occ_reg + 1'b1;
                                wr.we     = 1'b1;
                                wr.addr   = head_next;
                            end
                            else
                            begin
                                tail_next = step_fwd(tail_reg, cap);
                                occ_next  = occ_reg + 1'b1;
                                wr.we     = 1'b1;
                                wr.addr   = tail_next;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_REAR:
                        begin
                            if (occ_reg == '0)
                            begin
                                ok_next = 1'b0;
                            end
                            else if (occ_reg == CNT_W'(1))
                            begin
                                head_next = '0;
                                tail_next = '0;
                                occ_next  = '0;
                            end
                            else
                            begin
                                if (cmd_ch.cmd == CMD_POP_FRONT)
                                    head_next = step_fwd(head_reg, cap);
                                else
                                    tail_next = step_back(tail_reg, cap);
                                occ_next = occ_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            // query only
                        end
                    endcase
                    full_next = (occ_next >= cap);
                end
            end
            S_READ:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            capacity_reg  <= CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg   <= ok_next;
        full_reg <= full_next;
    end

    assign rsp_ch.valid       = out_valid_reg;
    assign rsp_ch.ok          = ok_reg;
    assign rsp_ch.is_empty    = (occ_reg == '0);
    assign rsp_ch.is_full     = full_reg;
    assign rsp_ch.front_value = (occ_reg == '0) ? '1 : rdata_front;
    assign rsp_ch.rear_value  = (occ_reg == '0) ? '1 : rdata_rear;

    `CDQ_ASSERT(a_occ_bound, int'(occ_reg) <= DEPTH, "occupancy above depth")
    `CDQ_ASSERT(a_empty_ptrs, occ_reg == '0 |-> (head_reg == '0 && tail_reg == '0),
                "empty deque with non-zero pointers")
    `CDQ_NEVER(a_read_no_rsp, state_reg == S_READ && out_valid_reg,
               "store read while a response is pending")
    `CDQ_ASSERT(a_refused_hold, (state_reg == S_READ && !ok_reg) |-> occ_reg == $past(occ_reg),
                "refused item changed occupancy")

endmodule

`default_nettype wire
